/* sv/pfm_nru_pkg.sv */
// ----------------------------------------------------------------------------
// pfm_nru_pkg
// Shared sizes, codes and sequencer states of the NRU page frame manager.
// ----------------------------------------------------------------------------
package pfm_nru_pkg;

  localparam int NUM_FRAMES = 128;
  localparam int NUM_PAGES  = 64;
  localparam int FRAME_W    = $clog2(NUM_FRAMES);
  localparam int PAGE_W     = $clog2(NUM_PAGES);
  localparam int SCAN_W     = (FRAME_W > PAGE_W) ? FRAME_W : PAGE_W;
  localparam int CNT_W      = 8;
  localparam int CFG_IDX_W  = 1;
  localparam int STATUS_W   = 3;

  localparam logic [CNT_W-1:0] RESERVED_RST  = 8'd60;
  localparam logic [CNT_W-1:0] THRESHOLD_RST = 8'd16;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_RESERVED  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD = 1'b1;

  // Request kinds.
  localparam logic KIND_FAULT  = 1'b0;
  localparam logic KIND_ACCESS = 1'b1;

  typedef enum logic [STATUS_W-1:0] {
    ST_LOADED_FREE  = 3'd0,
    ST_LOADED_EVICT = 3'd1,
    ST_ACCESS       = 3'd2,
    ST_NO_FRAME     = 3'd3,
    ST_INVALID      = 3'd4
  } pfm_status_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_ACC,
    S_COUNT,
    S_DECIDE,
    S_VICTIM,
    S_PICK,
    S_VRD,
    S_EVICT,
    S_FALLBACK,
    S_COMMIT,
    S_EMIT
  } pfm_state_e;

endpackage

/* sv/page_frame_manager_nru_top.sv */
// ----------------------------------------------------------------------------
// page_frame_manager_nru_top
// Page frame manager with not-recently-used replacement, built around one
// scan counter that walks the frame map and the page table under a sequencer.
// ----------------------------------------------------------------------------
// Usage:
// Requests arrive on the in_* channel (kind, page, is_write) and each one
// produces exactly one result transfer on the out_* channel. An access
// request marks a mapped page as used (and dirty on a write) and returns
// its frame. A fault request for an unmapped page counts the free
// allocatable frames, then either evicts an NRU victim (when the count is
// below swap_threshold) or takes the lowest free frame, or else reports
// that no frame is left. The block works on one request at a time. An
// invalid request goes straight to the result, and an access first reads
// the frame number memory. The free count checks one frame per cycle and
// the victim scan, run only when the count is below the threshold, one
// page per cycle. The sequencer returns to idle as the result is
// registered, so the next request can be taken while that result is
// presented. The single scan counter and the registered read of the frame
// number memory set this pace.
// Results sit in an output register; a new request is taken while an older
// result still waits, and a finished request holds in its last state while
// the receiver stalls. Reset clears all map bits and loads reserved_frames
// with 60 and swap_threshold with 16; the frame number memory is not
// cleared, as it is only read for mapped pages. Configuration writes are
// always taken and are meant to be issued while the block is idle.
// ----------------------------------------------------------------------------
module page_frame_manager_nru_top
  import pfm_nru_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // Request channel.
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic                 kind_i,
  input  logic [PAGE_W-1:0]    page_i,
  input  logic                 is_write_i,
  // Result channel.
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [STATUS_W-1:0]  status_o,
  output logic [FRAME_W-1:0]   frame_o,
  output logic [PAGE_W-1:0]    victim_page_o,
  output logic                 write_back_o,
  output logic [CNT_W-1:0]     free_count_o,
  // Configuration write channel.
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [CNT_W-1:0]     cfg_data_i
);

  pfm_state_e state_q, state_d;

  // Configuration registers.
  logic [CNT_W-1:0] reserved_q;
  logic [CNT_W-1:0] threshold_q;

  // Frame map and page table bits, all cleared at reset.
  logic [NUM_FRAMES-1:0] frame_used_q;
  logic [NUM_PAGES-1:0]  entry_valid_q;
  logic [NUM_PAGES-1:0]  entry_use_q;
  logic [NUM_PAGES-1:0]  entry_dirty_q;

  // Frame number of each page, only meaningful while the page is mapped.
  logic [FRAME_W-1:0] frame_mem [NUM_PAGES];
  logic [FRAME_W-1:0] rdata_q;
  logic [PAGE_W-1:0]  rd_addr;
  logic               mem_we;

  // Request registers.
  logic [PAGE_W-1:0] page_q;

  // Scan state.
  logic [SCAN_W-1:0]  idx_q;
  logic [CNT_W-1:0]   cnt_q;
  logic               low_found_q;
  logic [FRAME_W-1:0] low_q;
  logic [3:0]         fnd_q;
  logic [PAGE_W-1:0]  cls_vic_q [4];
  logic [PAGE_W-1:0]  vic_q;
  logic [FRAME_W-1:0] tgt_q;

  // Result being built and the output register.
  pfm_status_e        res_status_q;
  logic [FRAME_W-1:0] res_frame_q;
  logic [PAGE_W-1:0]  res_victim_q;
  logic               res_wb_q;
  logic [CNT_W-1:0]   res_free_q;

  logic               out_valid_q;
  logic [STATUS_W-1:0] out_status_q;
  logic [FRAME_W-1:0] out_frame_q;
  logic [PAGE_W-1:0]  out_victim_q;
  logic               out_wb_q;
  logic [CNT_W-1:0]   out_free_q;

  // Scan helpers.
  logic [FRAME_W-1:0] scan_frame;
  logic [PAGE_W-1:0]  scan_page;
  logic               frame_is_free;
  logic               frames_last;
  logic               pages_last;
  logic               in_xfer;
  logic               emit;
  logic               pv, pu, pd;

  assign scan_frame    = idx_q[FRAME_W-1:0];
  assign scan_page     = idx_q[PAGE_W-1:0];
  assign frame_is_free = (CNT_W'(scan_frame) >= reserved_q) && !frame_used_q[scan_frame];
  assign frames_last   = (scan_frame == FRAME_W'(NUM_FRAMES - 1));
  assign pages_last    = (scan_page == PAGE_W'(NUM_PAGES - 1));
  assign in_xfer       = in_valid_i && in_ready_o;
  assign emit          = (state_q == S_EMIT) && (!out_valid_q || out_ready_i);
  assign pv            = entry_valid_q[scan_page];
  assign pu            = entry_use_q[scan_page];
  assign pd            = entry_dirty_q[scan_page];

  assign cfg_ready_o = 1'b1;

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_xfer) begin
          if (kind_i == KIND_ACCESS) begin
            state_d = entry_valid_q[page_i] ? S_ACC : S_EMIT;
          end else begin
            state_d = entry_valid_q[page_i] ? S_EMIT : S_COUNT;
          end
        end
      end
      S_ACC:      state_d = S_EMIT;
      S_COUNT:    if (frames_last) state_d = S_DECIDE;
      S_DECIDE:   state_d = (cnt_q < threshold_q) ? S_VICTIM : S_FALLBACK;
      S_VICTIM:   if (pages_last) state_d = S_PICK;
      S_PICK:     state_d = (|fnd_q) ? S_VRD : S_FALLBACK;
      S_VRD:      state_d = S_EVICT;
      S_EVICT:    state_d = S_COMMIT;
      S_FALLBACK: state_d = low_found_q ? S_COMMIT : S_EMIT;
      S_COMMIT:   state_d = S_EMIT;
      S_EMIT:     if (emit) state_d = S_IDLE;
      default:    state_d = S_IDLE;
    endcase
  end

  // Sequencer outputs.
  always_comb begin
    in_ready_o = (state_q == S_IDLE);
    rd_addr    = (state_q == S_IDLE) ? page_i : vic_q;
    mem_we     = (state_q == S_COMMIT);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      reserved_q  <= RESERVED_RST;
      threshold_q <= THRESHOLD_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        CFG_RESERVED:  reserved_q  <= cfg_data_i;
        CFG_THRESHOLD: threshold_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Frame number memory with a registered read port.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      frame_mem[page_q] <= tgt_q;
    end
    rdata_q <= frame_mem[rd_addr];
  end

  // Map and table bits.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_used_q  <= '0;
      entry_valid_q <= '0;
      entry_use_q   <= '0;
      entry_dirty_q <= '0;
    end else begin
      if (in_xfer && (kind_i == KIND_ACCESS) && entry_valid_q[page_i]) begin
        entry_use_q[page_i] <= 1'b1;
        if (is_write_i) begin
          entry_dirty_q[page_i] <= 1'b1;
        end
      end
      if (state_q == S_EVICT) begin
        entry_valid_q[vic_q] <= 1'b0;
      end
      if (state_q == S_COMMIT) begin
        frame_used_q[tgt_q]   <= 1'b1;
        entry_valid_q[page_q] <= 1'b1;
        entry_use_q[page_q]   <= 1'b0;
        entry_dirty_q[page_q] <= 1'b0;
      end
    end
  end

  // Scan datapath and result building.
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      S_IDLE: begin
        if (in_xfer) begin
          page_q       <= page_i;
          res_status_q <= ST_INVALID;
          res_frame_q  <= '0;
          res_victim_q <= '0;
          res_wb_q     <= 1'b0;
          res_free_q   <= '0;
          idx_q        <= '0;
          cnt_q        <= '0;
          low_found_q  <= 1'b0;
          low_q        <= '0;
          fnd_q        <= '0;
        end
      end
      S_ACC: begin
        res_status_q <= ST_ACCESS;
        res_frame_q  <= rdata_q;
      end
      S_COUNT: begin
        if (frame_is_free) begin
          cnt_q <= cnt_q + CNT_W'(1);
          if (!low_found_q) begin
            low_found_q <= 1'b1;
            low_q       <= scan_frame;
          end
        end
        idx_q <= frames_last ? '0 : idx_q + SCAN_W'(1);
      end
      S_DECIDE: begin
        res_free_q   <= cnt_q;
        res_status_q <= ST_NO_FRAME;
      end
      S_VICTIM: begin
        // First page of NRU classes 0-2 and first mapped page, in one pass.
        if (pv && !pu && !pd && !fnd_q[0]) begin
          fnd_q[0] <= 1'b1; cls_vic_q[0] <= scan_page;
        end
        if (pv && !pu && pd && !fnd_q[1]) begin
          fnd_q[1] <= 1'b1; cls_vic_q[1] <= scan_page;
        end
        if (pv && pu && !pd && !fnd_q[2]) begin
          fnd_q[2] <= 1'b1; cls_vic_q[2] <= scan_page;
        end
        if (pv && !fnd_q[3]) begin
          fnd_q[3] <= 1'b1; cls_vic_q[3] <= scan_page;
        end
        idx_q <= pages_last ? '0 : idx_q + SCAN_W'(1);
      end
      S_PICK: begin
        priority if (fnd_q[0]) vic_q <= cls_vic_q[0];
        else if (fnd_q[1])     vic_q <= cls_vic_q[1];
        else if (fnd_q[2])     vic_q <= cls_vic_q[2];
        else                   vic_q <= cls_vic_q[3];
      end
      S_EVICT: begin
        tgt_q        <= rdata_q;
        res_status_q <= ST_LOADED_EVICT;
        res_frame_q  <= rdata_q;
        res_victim_q <= vic_q;
        res_wb_q     <= entry_dirty_q[vic_q];
      end
      S_FALLBACK: begin
        if (low_found_q) begin
          tgt_q        <= low_q;
          res_status_q <= ST_LOADED_FREE;
          res_frame_q  <= low_q;
        end
      end
      default: ;
    endcase
  end

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_status_q <= res_status_q;
      out_frame_q  <= res_frame_q;
      out_victim_q <= res_victim_q;
      out_wb_q     <= res_wb_q;
      out_free_q   <= res_free_q;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign status_o      = out_status_q;
  assign frame_o       = out_frame_q;
  assign victim_page_o = out_victim_q;
  assign write_back_o  = out_wb_q;
  assign free_count_o  = out_free_q;

  // A freshly allocated free frame must not already be in use.
  a_free_frame_unused: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_COMMIT && res_status_q == ST_LOADED_FREE) |-> !frame_used_q[tgt_q])
    else $error("free allocation targets a used frame");

  // The free count can never exceed the number of frames already scanned.
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_COUNT) |-> (cnt_q <= CNT_W'(scan_frame)))
    else $error("free count ran ahead of the scan");

  // The victim is a mapped page other than the faulting one.
  a_victim_mapped: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_EVICT) |-> (entry_valid_q[vic_q] && vic_q != page_q))
    else $error("victim is not a mapped page");

  // After a commit the new mapping is valid, unused and clean.
  a_commit_fresh: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_COMMIT) |=>
      (entry_valid_q[page_q] && !entry_use_q[page_q] && !entry_dirty_q[page_q]))
    else $error("new mapping not installed clean");

endmodule
